// ===== rtl/core/vucrp_pkg.sv =====
// Package with the shared types, codes and constants of the video unit register port.
`default_nettype none
package vucrp_pkg;
	localparam int NAME_TABLE_BYTES_DEF = 4096;
	localparam int LAST_VISIBLE_LINE_DEF = 239;
	localparam int PATTERN_BYTES = 8192;
	localparam int PAT_AW = $clog2(PATTERN_BYTES);

	localparam logic [1:0] KIND_READ = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_VBLANK = 2'd2;

	localparam logic [2:0] REG_CTRL = 3'd0;
	localparam logic [2:0] REG_MASK = 3'd1;
	localparam logic [2:0] REG_STATUS = 3'd2;
	localparam logic [2:0] REG_OAM_ADDR = 3'd3;
	localparam logic [2:0] REG_OAM_DATA = 3'd4;
	localparam logic [2:0] REG_SCROLL = 3'd5;
	localparam logic [2:0] REG_ADDR = 3'd6;
	localparam logic [2:0] REG_DATA = 3'd7;

	localparam logic [2:0] MIR_HORZ = 3'd0;
	localparam logic [2:0] MIR_VERT = 3'd1;
	localparam logic [2:0] MIR_UPPER = 3'd2;
	localparam logic [2:0] MIR_LOWER = 3'd3;
	localparam logic [2:0] MIR_FOUR = 3'd4;

	localparam logic CFG_MIRROR = 1'b0;
	localparam logic CFG_DISABLE = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] register_select;
		logic [7:0] write_data;
		logic debug_peek;
		logic [8:0] scanline;
	} vucrp_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic nmi_request;
	} vucrp_rsp_t;

	typedef struct packed {
		logic load;
		logic commit;
		logic clr_we;
		logic [PAT_AW-1:0] clr_addr;
	} vucrp_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/core/vucrp_ctrl.sv =====
// Controller state machine that sequences the clearing pass and each word.
`default_nettype none
module vucrp_ctrl import vucrp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output vucrp_cmd_t cmd
);
	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_RD = 2'd2;
	localparam logic [1:0] S_FIN = 2'd3;

	logic [1:0] state_q;
	logic [PAT_AW-1:0] clr_cnt_q;
	logic rsp_valid_q;
	logic out_free;
	logic load;
	logic commit;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign commit = (state_q == S_FIN) && out_free;
	assign req_stall = !((state_q == S_IDLE) || commit);
	assign load = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;

	assign cmd.load = load;
	assign cmd.commit = commit;
	assign cmd.clr_we = (state_q == S_CLEAR);
	assign cmd.clr_addr = clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == PAT_AW'(PATTERN_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (load) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (commit) begin
						state_q <= load ? S_RD : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/vucrp_datapath.sv =====
// Datapath with the CPU-visible registers, the video memories and the result register.
`default_nettype none
module vucrp_datapath import vucrp_pkg::*; #(
	parameter int NAME_TABLE_BYTES = NAME_TABLE_BYTES_DEF,
	parameter int LAST_VISIBLE_LINE = LAST_VISIBLE_LINE_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire vucrp_cmd_t cmd,
	input wire vucrp_req_t req_word,
	output vucrp_rsp_t rsp_word,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [2:0] cfg_data
);
	localparam int NAW = $clog2(NAME_TABLE_BYTES);

	vucrp_req_t item_q;
	logic [2:0] mirror_q;
	logic disabled_q;
	logic [7:0] ctrl_q;
	logic [7:0] mask_q;
	logic vblank_q;
	logic [7:0] spr_addr_q;
	logic [14:0] cur_q;
	logic [14:0] staged_q;
	logic toggle_q;
	logic [7:0] rbuf_q;
	logic [7:0] pal_q [32];
	vucrp_rsp_t rsp_q;

	logic [7:0] spr_mem [256];
	logic [7:0] pat_mem [PATTERN_BYTES];
	logic [7:0] name_mem [NAME_TABLE_BYTES];
	logic [7:0] spr_rd_q;
	logic [7:0] pat_rd_q;
	logic [7:0] name_rd_q;

	logic [11:0] name_raw;
	logic [12:0] name_wide;
	logic [NAW-1:0] name_addr;
	logic [4:0] pal_idx;
	logic [13:0] va;
	logic [7:0] vram_val;
	logic is_pal;
	logic blocked;
	logic [14:0] cur_next;

	logic [7:0] rd;
	logic nmi;
	logic vblank_d;
	logic toggle_d;
	logic [7:0] ctrl_d;
	logic [7:0] mask_d;
	logic [7:0] spr_addr_d;
	logic [14:0] cur_d;
	logic [14:0] staged_d;
	logic [7:0] rbuf_d;
	logic spr_we;
	logic vram_we;

	assign va = cur_q[13:0];

	always_comb begin
		case (mirror_q)
			MIR_HORZ: name_raw = {va[11], 1'b0, va[9:0]};
			MIR_UPPER: name_raw = {2'b00, va[9:0]};
			MIR_LOWER: name_raw = {2'b10, va[9:0]};
			MIR_FOUR: name_raw = va[11:0];
			default: name_raw = {1'b0, va[10:0]};
		endcase
		name_wide = {1'b0, name_raw};
		if (name_wide >= 13'(NAME_TABLE_BYTES)) begin
			name_wide = name_wide - 13'(NAME_TABLE_BYTES);
		end
		name_addr = name_wide[NAW-1:0];
		pal_idx = va[4:0];
		if (va[1:0] == 2'b00) begin
			pal_idx[4] = 1'b0;
		end
	end

	assign is_pal = (va[13:8] == 6'h3F);
	assign vram_val = !va[13] ? pat_rd_q : (is_pal ? {2'b00, pal_q[pal_idx][5:0]} : name_rd_q);
	assign blocked = (mask_q[4:3] != 2'b00) && (item_q.scanline <= 9'(LAST_VISIBLE_LINE));
	assign cur_next = cur_q + (ctrl_q[2] ? 15'd32 : 15'd1);

	always_comb begin
		rd = 8'h00;
		nmi = 1'b0;
		vblank_d = vblank_q;
		toggle_d = toggle_q;
		ctrl_d = ctrl_q;
		mask_d = mask_q;
		spr_addr_d = spr_addr_q;
		cur_d = cur_q;
		staged_d = staged_q;
		rbuf_d = rbuf_q;
		spr_we = 1'b0;
		vram_we = 1'b0;
		case (item_q.kind)
			KIND_READ: begin
				if (!item_q.debug_peek && disabled_q) begin
					rd = 8'hFF;
				end else begin
					case (item_q.register_select)
						REG_STATUS: begin
							if (item_q.debug_peek) begin
								rd = {vblank_q, 7'd0};
							end else begin
								rd = {vblank_q, 2'b00, rbuf_q[4:0]};
								vblank_d = 1'b0;
								toggle_d = 1'b0;
							end
						end
						REG_OAM_DATA: begin
							if (item_q.debug_peek) begin
								rd = spr_rd_q;
							end else if (blocked) begin
								rd = 8'hFF;
							end else if (spr_addr_q[1:0] == 2'd2) begin
								rd = spr_rd_q & 8'hE3;
							end else begin
								rd = spr_rd_q;
							end
						end
						REG_DATA: begin
							if (item_q.debug_peek) begin
								rd = rbuf_q;
							end else begin
								rd = is_pal ? vram_val : rbuf_q;
								rbuf_d = vram_val;
								cur_d = cur_next;
							end
						end
						default: rd = 8'hFF;
					endcase
				end
			end
			KIND_WRITE: begin
				if (!disabled_q) begin
					case (item_q.register_select)
						REG_CTRL: begin
							ctrl_d = item_q.write_data;
							staged_d = {staged_q[14:12], item_q.write_data[1:0], staged_q[9:0]};
						end
						REG_MASK: mask_d = item_q.write_data;
						REG_OAM_ADDR: spr_addr_d = item_q.write_data;
						REG_OAM_DATA: begin
							if (!blocked) begin
								spr_we = 1'b1;
								spr_addr_d = spr_addr_q + 8'd1;
							end
						end
						REG_SCROLL: begin
							if (!toggle_q) begin
								staged_d = {staged_q[14:5], item_q.write_data[7:3]};
								toggle_d = 1'b1;
							end else begin
								staged_d = {item_q.write_data[2:0], staged_q[11:10],
									item_q.write_data[7:3], staged_q[4:0]};
								toggle_d = 1'b0;
							end
						end
						REG_ADDR: begin
							if (!toggle_q) begin
								staged_d = {1'b0, item_q.write_data[5:0], staged_q[7:0]};
								toggle_d = 1'b1;
							end else begin
								staged_d = {staged_q[14:8], item_q.write_data};
								cur_d = staged_d;
								toggle_d = 1'b0;
							end
						end
						REG_DATA: begin
							vram_we = 1'b1;
							cur_d = cur_next;
						end
						default: rd = 8'h00;
					endcase
				end
			end
			KIND_VBLANK: begin
				if (!disabled_q) begin
					vblank_d = 1'b1;
					nmi = ctrl_q[7];
				end
			end
			default: rd = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= MIR_VERT;
			disabled_q <= 1'b0;
			ctrl_q <= '0;
			mask_q <= '0;
			vblank_q <= 1'b0;
			spr_addr_q <= '0;
			cur_q <= '0;
			staged_q <= '0;
			toggle_q <= 1'b0;
			rbuf_q <= '0;
			for (int i = 0; i < 32; i++) begin
				pal_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MIRROR) begin
					mirror_q <= cfg_data;
				end else begin
					disabled_q <= cfg_data[0];
				end
			end
			if (cmd.commit) begin
				ctrl_q <= ctrl_d;
				mask_q <= mask_d;
				vblank_q <= vblank_d;
				spr_addr_q <= spr_addr_d;
				cur_q <= cur_d;
				staged_q <= staged_d;
				toggle_q <= toggle_d;
				rbuf_q <= rbuf_d;
				if (vram_we && va[13] && is_pal) begin
					pal_q[pal_idx] <= item_q.write_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req_word;
		end
		if (cmd.commit) begin
			rsp_q.read_data <= rd;
			rsp_q.nmi_request <= nmi;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_we) begin
			if (cmd.clr_addr[PAT_AW-1:8] == '0) begin
				spr_mem[cmd.clr_addr[7:0]] <= 8'h00;
			end
		end else if (cmd.commit && spr_we) begin
			spr_mem[spr_addr_q] <= item_q.write_data;
		end
		spr_rd_q <= spr_mem[spr_addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_we) begin
			pat_mem[cmd.clr_addr] <= 8'h00;
		end else if (cmd.commit && vram_we && !va[13]) begin
			pat_mem[va[PAT_AW-1:0]] <= item_q.write_data;
		end
		pat_rd_q <= pat_mem[va[PAT_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_we) begin
			if (cmd.clr_addr < PAT_AW'(NAME_TABLE_BYTES)) begin
				name_mem[cmd.clr_addr[NAW-1:0]] <= 8'h00;
			end
		end else if (cmd.commit && vram_we && va[13] && !is_pal) begin
			name_mem[name_addr] <= item_q.write_data;
		end
		name_rd_q <= name_mem[name_addr];
	end

	assign rsp_word = rsp_q;
endmodule
`default_nettype wire

// ===== rtl/core/video_unit_cpu_register_port_core.sv =====
// Top level of the video unit CPU register port.
// Each request word passes through a read state, for the registered read of the
// sprite, pattern and nametable memories, and a finish state, for the register
// update and result; the next word is taken in the finish state when the result
// register is free. After reset the block runs a clearing pass over the
// pattern, nametable and sprite memories and stalls requests until it ends;
// configuration writes are taken throughout.
`default_nettype none
module video_unit_cpu_register_port_core import vucrp_pkg::*; #(
	parameter int NAME_TABLE_BYTES = NAME_TABLE_BYTES_DEF,
	parameter int LAST_VISIBLE_LINE = LAST_VISIBLE_LINE_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire vucrp_req_t req_word,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output vucrp_rsp_t rsp_word,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [2:0] cfg_data
);
	vucrp_cmd_t cmd;

	vucrp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.cmd(cmd)
	);

	vucrp_datapath #(
		.NAME_TABLE_BYTES(NAME_TABLE_BYTES),
		.LAST_VISIBLE_LINE(LAST_VISIBLE_LINE)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.req_word(req_word),
		.rsp_word(rsp_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);
endmodule
`default_nettype wire

// ===== verif/tb_video_unit_cpu_register_port_core.sv =====
// Self-checking testbench for the video unit CPU register port core.
`timescale 1ns / 100ps
module tb_video_unit_cpu_register_port_core;
	import vucrp_pkg::*;

	localparam int NT_BYTES = NAME_TABLE_BYTES_DEF;
	localparam int LAST_LINE = LAST_VISIBLE_LINE_DEF;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	vucrp_req_t req_word = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	vucrp_rsp_t rsp_word;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [2:0] cfg_data = '0;

	video_unit_cpu_register_port_core u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Mirror of the register and memory state.
	logic [2:0] m_mirror;
	logic m_disabled;
	logic [7:0] m_ctrl, m_mask, m_oam_addr, m_rbuf;
	logic m_vblank, m_toggle;
	logic [2:0] m_fine_x;
	logic [14:0] m_v, m_t;
	logic [7:0] m_oam [256];
	logic [7:0] m_pal [32];
	logic [7:0] m_names [NT_BYTES];
	logic [7:0] m_pattern [PATTERN_BYTES];

	vucrp_rsp_t pending_rsp [$];
	int errors = 0;
	int cycles = 0;
	bit long_hold = 1'b0;

	typedef struct {
		vucrp_req_t word;
		bit known;
		vucrp_rsp_t rsp;
	} stim_row_t;

	function automatic int name_slot(logic [13:0] a);
		logic [15:0] x;
		logic [15:0] r;
		x = 16'h2000 | (a & 16'h0FFF);
		case (m_mirror)
			MIR_HORZ: r = (x < 16'h2800) ? (16'h2000 | (x & 16'h03FF))
				: (16'h2800 | (x & 16'h03FF));
			MIR_UPPER: r = 16'h2000 | (x & 16'h03FF);
			MIR_LOWER: r = 16'h2800 | (x & 16'h03FF);
			MIR_FOUR: r = x;
			default: r = 16'h2000 | (x & 16'h07FF);
		endcase
		return int'(r & 16'h0FFF) % NT_BYTES;
	endfunction

	function automatic int pal_slot(logic [13:0] a);
		logic [4:0] p;
		p = a[4:0];
		if ((p & 5'h13) == 5'h10) p = p & 5'h0F;
		return int'(p);
	endfunction

	function automatic logic [7:0] vmem_load(logic [14:0] va);
		logic [13:0] a;
		a = va[13:0];
		if (a < 14'h2000) return m_pattern[a];
		if (a < 14'h3F00) return m_names[name_slot(a)];
		return m_pal[pal_slot(a)] & 8'h3F;
	endfunction

	function automatic void vmem_store(logic [14:0] va, logic [7:0] d);
		logic [13:0] a;
		a = va[13:0];
		if (a < 14'h2000) m_pattern[a] = d;
		else if (a < 14'h3F00) m_names[name_slot(a)] = d;
		else m_pal[pal_slot(a)] = d;
	endfunction

	function automatic void advance_vaddr();
		m_v = m_v + (m_ctrl[2] ? 15'd32 : 15'd1);
	endfunction

	function automatic bit oam_locked(logic [8:0] line);
		return (m_mask[4:3] != 2'b00) && (line <= LAST_LINE);
	endfunction

	function automatic void clear_state();
		m_mirror = MIR_VERT; m_disabled = 1'b0;
		m_ctrl = '0; m_mask = '0; m_oam_addr = '0; m_rbuf = '0;
		m_vblank = 1'b0; m_toggle = 1'b0; m_fine_x = '0; m_v = '0; m_t = '0;
		foreach (m_oam[i]) m_oam[i] = '0;
		foreach (m_pal[i]) m_pal[i] = '0;
		foreach (m_names[i]) m_names[i] = '0;
		foreach (m_pattern[i]) m_pattern[i] = '0;
	endfunction

	function automatic vucrp_rsp_t register_access(vucrp_req_t w);
		vucrp_rsp_t r;
		logic [7:0] v;
		logic [7:0] d;
		r = '0;
		d = w.write_data;
		if (w.kind == KIND_READ) begin
			if (!w.debug_peek && m_disabled) begin
				r.read_data = 8'hFF;
			end else begin
				case (w.register_select)
					REG_STATUS: begin
						if (w.debug_peek) begin
							r.read_data = {m_vblank, 7'd0};
						end else begin
							r.read_data = {m_vblank, 2'b00, m_rbuf[4:0]};
							m_vblank = 1'b0;
							m_toggle = 1'b0;
						end
					end
					REG_OAM_DATA: begin
						v = m_oam[m_oam_addr];
						if (!w.debug_peek) begin
							if (oam_locked(w.scanline)) v = 8'hFF;
							else if (m_oam_addr[1:0] == 2'd2) v = v & 8'hE3;
						end
						r.read_data = v;
					end
					REG_DATA: begin
						if (w.debug_peek) begin
							r.read_data = m_rbuf;
						end else begin
							v = m_rbuf;
							m_rbuf = vmem_load(m_v);
							if (m_v[13:0] >= 14'h3F00) v = m_rbuf;
							advance_vaddr();
							r.read_data = v;
						end
					end
					default: r.read_data = 8'hFF;
				endcase
			end
		end else if (w.kind == KIND_WRITE) begin
			if (!m_disabled) begin
				case (w.register_select)
					REG_CTRL: begin
						m_ctrl = d;
						m_t[11:10] = d[1:0];
					end
					REG_MASK: m_mask = d;
					REG_OAM_ADDR: m_oam_addr = d;
					REG_OAM_DATA: begin
						if (!oam_locked(w.scanline)) begin
							m_oam[m_oam_addr] = d;
							m_oam_addr = m_oam_addr + 8'd1;
						end
					end
					REG_SCROLL: begin
						if (!m_toggle) begin
							m_fine_x = d[2:0];
							m_t[4:0] = d[7:3];
						end else begin
							m_t[14:12] = d[2:0];
							m_t[9:5] = d[7:3];
						end
						m_toggle = ~m_toggle;
					end
					REG_ADDR: begin
						if (!m_toggle) begin
							m_t[14] = 1'b0;
							m_t[13:8] = d[5:0];
						end else begin
							m_t[7:0] = d;
							m_v = m_t;
						end
						m_toggle = ~m_toggle;
					end
					REG_DATA: begin
						vmem_store(m_v, d);
						advance_vaddr();
					end
					default: ;
				endcase
			end
		end else if (w.kind == KIND_VBLANK) begin
			if (!m_disabled) begin
				m_vblank = 1'b1;
				r.nmi_request = m_ctrl[7];
			end
		end
		return r;
	endfunction

	function automatic vucrp_req_t make_word(logic [1:0] k, logic [2:0] s, logic [7:0] d,
			logic p, logic [8:0] line);
		vucrp_req_t w;
		w.kind = k; w.register_select = s; w.write_data = d;
		w.debug_peek = p; w.scanline = line;
		return w;
	endfunction

	task automatic send_word(vucrp_req_t w, bit known, vucrp_rsp_t want);
		vucrp_rsp_t r;
		r = register_access(w);
		if (known && r !== want) begin
			$error("table row: predicted %h, table says %h", r, want);
			errors++;
		end
		pending_rsp.push_back(r);
		req_word <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic sender_gap();
		int n;
		n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic idx, logic [2:0] value);
		while (pending_rsp.size() != 0) @(posedge clk);
		req_valid <= 1'b0;
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MIRROR) m_mirror = value;
		else m_disabled = value[0];
	endtask

	function automatic vucrp_req_t random_word();
		vucrp_req_t w;
		int pick;
		w.kind = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		w.register_select = 3'($urandom_range(0, 7));
		w.write_data = 8'($urandom);
		w.debug_peek = ($urandom_range(0, 5) == 0);
		pick = $urandom_range(0, 3);
		w.scanline = (pick == 0) ? 9'd511 : 9'($urandom_range(0, 261));
		if (w.kind != KIND_VBLANK && $urandom_range(0, 2) == 0) begin
			w.register_select = ($urandom_range(0, 1) == 1) ? REG_DATA : REG_ADDR;
			if (w.register_select == REG_ADDR && $urandom_range(0, 1) == 1)
				w.write_data = 8'($urandom_range(0, 63)) | (m_toggle ? 8'h00 : 8'h00);
			w.kind = ($urandom_range(0, 1) == 1) ? KIND_WRITE : KIND_READ;
		end
		if (w.kind == KIND_WRITE && w.register_select == REG_MASK && $urandom_range(0, 1))
			w.write_data[4:3] = 2'b00;
		return w;
	endfunction

	// Directed table: reset values, extremes and special cases.
	stim_row_t dir_rows [$];

	initial begin
		vucrp_rsp_t none;
		none = '0;
		dir_rows = '{
			'{make_word(KIND_READ, REG_STATUS, 8'h00, 1'b0, 9'd0), 1, '{8'h00, 1'b0}},
			'{make_word(KIND_READ, REG_CTRL, 8'h00, 1'b0, 9'd0), 1, '{8'hFF, 1'b0}},
			'{make_word(KIND_READ, REG_MASK, 8'h00, 1'b1, 9'd0), 1, '{8'hFF, 1'b0}},
			'{make_word(KIND_READ, REG_OAM_ADDR, 8'h00, 1'b0, 9'd0), 1, '{8'hFF, 1'b0}},
			'{make_word(KIND_READ, REG_SCROLL, 8'h00, 1'b0, 9'd0), 1, '{8'hFF, 1'b0}},
			'{make_word(KIND_READ, REG_ADDR, 8'h00, 1'b0, 9'd0), 1, '{8'hFF, 1'b0}},
			'{make_word(KIND_VBLANK, 3'd0, 8'h00, 1'b0, 9'd0), 1, '{8'h00, 1'b0}},
			'{make_word(KIND_READ, REG_STATUS, 8'h00, 1'b1, 9'd0), 1, '{8'h80, 1'b0}},
			'{make_word(KIND_WRITE, REG_CTRL, 8'hFF, 1'b0, 9'd0), 1, none},
			'{make_word(KIND_VBLANK, 3'd7, 8'hFF, 1'b1, 9'd511), 1, '{8'h00, 1'b1}},
			'{make_word(2'd3, 3'd7, 8'hFF, 1'b1, 9'd511), 1, none},
			'{make_word(KIND_WRITE, REG_CTRL, 8'h00, 1'b0, 9'd261), 1, none},
			'{make_word(KIND_WRITE, REG_ADDR, 8'h3F, 1'b0, 9'd0), 0, none},
			'{make_word(KIND_WRITE, REG_ADDR, 8'h12, 1'b0, 9'd0), 0, none},
			'{make_word(KIND_WRITE, REG_DATA, 8'hFF, 1'b0, 9'd0), 0, none},
			'{make_word(KIND_WRITE, REG_ADDR, 8'h3F, 1'b0, 9'd0), 0, none},
			'{make_word(KIND_WRITE, REG_ADDR, 8'h02, 1'b0, 9'd0), 0, none},
			'{make_word(KIND_READ, REG_DATA, 8'h00, 1'b0, 9'd0), 0, none},
			'{make_word(KIND_READ, REG_DATA, 8'h00, 1'b1, 9'd0), 0, none},
			'{make_word(KIND_WRITE, REG_OAM_ADDR, 8'h02, 1'b0, 9'd0), 0, none},
			'{make_word(KIND_WRITE, REG_OAM_DATA, 8'hFF, 1'b0, 9'd0), 0, none},
			'{make_word(KIND_WRITE, REG_OAM_ADDR, 8'h02, 1'b0, 9'd0), 0, none},
			'{make_word(KIND_READ, REG_OAM_DATA, 8'h00, 1'b0, 9'd0), 1, '{8'hE3, 1'b0}},
			'{make_word(KIND_WRITE, REG_MASK, 8'h18, 1'b0, 9'd0), 0, none},
			'{make_word(KIND_READ, REG_OAM_DATA, 8'h00, 1'b0, 9'd239), 1, '{8'hFF, 1'b0}}
		};
	end

	initial begin
		logic [2:0] modes [6];
		clear_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].word, dir_rows[i].known, dir_rows[i].rsp);
			if (i % 4 == 3) sender_gap();
		end
		req_valid <= 1'b0;
		modes = '{MIR_HORZ, MIR_UPPER, MIR_LOWER, MIR_FOUR, 3'd7, MIR_VERT};
		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 6) write_reg(CFG_MIRROR, modes[ph]);
			if (ph == 6) write_reg(CFG_DISABLE, 3'd1);
			if (ph == 7) write_reg(CFG_DISABLE, 3'd0);
			for (int k = 0; k < 116; k++) begin
				if (ph == 2 && k == 30) long_hold = 1'b1;
				send_word(random_word(), 1'b0, '0);
				if (k % 9 > 5) sender_gap();
			end
			req_valid <= 1'b0;
		end
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("[video_unit_cpu_register_port_core] OK");
		else
			$display("[video_unit_cpu_register_port_core] ERROR");
		$finish;
	end

	// Receiver stall pattern, with one long hold to back up the block.
	initial begin
		int phase;
		phase = 0;
		forever begin
			@(posedge clk);
			phase++;
			if (long_hold) begin
				rsp_stall <= 1'b1;
				repeat (60) @(posedge clk);
				long_hold = 1'b0;
				rsp_stall <= 1'b0;
			end else if ((phase / 200) % 2 == 1) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	always @(posedge clk) begin
		vucrp_rsp_t want;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[video_unit_cpu_register_port_core] ERROR");
			$finish;
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected response word %h", rsp_word);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_word.read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data,
						rsp_word.read_data);
					errors++;
				end
				if (rsp_word.nmi_request !== want.nmi_request) begin
					$error("nmi_request: expected %b, got %b", want.nmi_request,
						rsp_word.nmi_request);
					errors++;
				end
			end
		end
	end
endmodule
